[rtl/sha1s_pkg.sv]
`default_nettype none
package sha1s_pkg;

    // item kinds on the input tuser
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_FINAL = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD  = 3'd4;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] END_POS    = 6'd63;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    localparam t_work SHA1_IV = '{
        a: 32'h67452301,
        b: 32'hEFCDAB89,
        c: 32'h98BADCFE,
        d: 32'h10325476,
        e: 32'hC3D2E1F0
    };

    // message schedule window, word 0 is the oldest (most significant)
    typedef logic [0:15][31:0] t_blk;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

[rtl/sha1s_round.sv]
`default_nettype none
module sha1s_round (
    input  logic [6:0]         i_round,
    input  sha1s_pkg::t_work   i_work,
    input  logic [31:0]        i_w,
    output sha1s_pkg::t_work   o_work
);
    import sha1s_pkg::*;

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;

    always_comb begin
        if (i_round < 7'd20) begin
            f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k = K_R0;
        end else if (i_round < 7'd40) begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = K_R1;
        end else if (i_round < 7'd60) begin
            f = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k = K_R2;
        end else begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = K_R3;
        end
        t = {i_work.a[26:0], i_work.a[31:27]} + f + i_work.e + i_w + k;
        o_work.a = t;
        o_work.b = i_work.a;
        o_work.c = {i_work.b[1:0], i_work.b[31:2]};
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule
`default_nettype wire

[rtl/sha1_stream_hash.sv]
`default_nettype none
// Channel   Dir  Fields (low bit up)                     Handshake
// s_axis    in   tdata: byte_value[7:0]                   tvalid/tready
//                tuser: kind[1:0]
// m_axis    out  tdata: digest_word[31:0]                 tvalid/tready
//                tuser: word_index[2:0], tlast: last
//
// A message byte is accepted while idle. The 64th byte of a block starts
// a compression: 80 rounds on the single shared round unit, then a fold of
// the working words into the chaining words.
// End of message: padding (9 to 72 bytes) goes in one byte per cycle, paused
// by one or two compressions, then five digest words, one per accepted item.
// Reset is synchronous, active low; chaining words return to the initial values.
// Input is not ready during rounds, the fold, padding or digest output; a stalled
// digest word holds until taken.
module sha1_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_value[7:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word[31:0]
    output logic [2:0]  m_axis_tuser,   // word_index[2:0]
    output logic        m_axis_tlast
);
    import sha1s_pkg::*;

    t_state      r_state, n_state;
    t_blk        r_blk, n_blk;
    t_work       r_chain, n_chain;
    t_work       r_work, n_work;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_bit_len, n_bit_len;
    logic [6:0]  r_round, n_round;
    logic        r_finish, n_finish;       // message end seen, padding pending
    logic        r_pad_first, n_pad_first; // next pad byte is 0x80
    logic        r_len_phase, n_len_phase; // length bytes going in
    logic        r_final_blk, n_final_blk; // compression under way is the last
    logic [2:0]  r_out_idx, n_out_idx;

    logic        in_acc;
    logic        out_acc;
    logic        out_done;
    logic        put_en;
    logic [7:0]  put_byte;
    logic [7:0]  pad_byte;
    logic [7:0]  len_byte;
    logic        wrap;
    logic        is_byte;
    logic        is_end;
    logic [31:0] w_new;
    logic [31:0] w_mix;
    logic [511:0] shifted;
    t_work       round_out;

    sha1s_round u_round (
        .i_round (r_round),
        .i_work  (r_work),
        .i_w     (r_blk[0]),
        .o_work  (round_out)
    );

    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign out_acc  = m_axis_tvalid & m_axis_tready;
    assign out_done = out_acc && (r_out_idx == LAST_WORD);
    assign is_byte  = (s_axis_tuser == KIND_BYTE) || (s_axis_tuser == KIND_FINAL);
    assign is_end   = (s_axis_tuser == KIND_FINAL) || (s_axis_tuser == KIND_END);

    // length bytes at slots 56..63, most significant first
    assign len_byte = 8'(r_bit_len >> {~r_pos[2:0], 3'b000});
    assign pad_byte = r_pad_first ? PAD_BYTE :
                      (r_len_phase || (r_pos == LEN_POS)) ? len_byte : 8'h00;

    assign wrap    = put_en && (r_pos == END_POS);
    assign w_mix   = r_blk[13] ^ r_blk[8] ^ r_blk[2] ^ r_blk[0];
    assign w_new   = {w_mix[30:0], w_mix[31]};
    // oldest byte drops out, new byte enters at the bottom
    assign shifted = {r_blk[0][23:0], r_blk[1:15], put_byte};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_axis_tuser)
                        KIND_BYTE:  n_state = wrap ? ST_ROUND : ST_IDLE;
                        KIND_FINAL: n_state = wrap ? ST_ROUND : ST_PAD;
                        KIND_END:   n_state = ST_PAD;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ROUND: begin
                if (r_round == LAST_ROUND) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                n_state = r_final_blk ? ST_OUT : (r_finish ? ST_PAD : ST_IDLE);
            end
            ST_PAD: begin
                if (wrap) n_state = ST_ROUND;
            end
            ST_OUT: begin
                if (out_done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and strobes
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        put_en        = 1'b0;
        put_byte      = s_axis_tdata;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                put_en        = in_acc && is_byte;
            end
            ST_PAD: begin
                put_en   = 1'b1;
                put_byte = pad_byte;
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
            end
            default: begin
                put_en = 1'b0;
            end
        endcase
        case (r_out_idx)
            3'd0:    m_axis_tdata = r_chain.a;
            3'd1:    m_axis_tdata = r_chain.b;
            3'd2:    m_axis_tdata = r_chain.c;
            3'd3:    m_axis_tdata = r_chain.d;
            default: m_axis_tdata = r_chain.e;
        endcase
        m_axis_tuser = r_out_idx;
        m_axis_tlast = (r_out_idx == LAST_WORD);
    end

    // datapath next values
    always_comb begin
        n_blk       = r_blk;
        n_chain     = r_chain;
        n_work      = r_work;
        n_pos       = r_pos;
        n_bit_len   = r_bit_len;
        n_round     = r_round;
        n_finish    = r_finish;
        n_pad_first = r_pad_first;
        n_len_phase = r_len_phase;
        n_final_blk = r_final_blk;
        n_out_idx   = r_out_idx;

        if (put_en) begin
            n_blk = shifted;
            n_pos = r_pos + 6'd1;
        end
        if (wrap) n_work = r_chain;

        case (r_state)
            ST_IDLE: begin
                if (in_acc && is_byte) n_bit_len = r_bit_len + 64'd8;
                if (in_acc && is_end) begin
                    n_finish    = 1'b1;
                    n_pad_first = 1'b1;
                end
            end
            ST_ROUND: begin
                n_blk   = {r_blk[1:15], w_new};
                n_work  = round_out;
                n_round = (r_round == LAST_ROUND) ? 7'd0 : r_round + 7'd1;
            end
            ST_FOLD: begin
                n_chain.a = r_chain.a + r_work.a;
                n_chain.b = r_chain.b + r_work.b;
                n_chain.c = r_chain.c + r_work.c;
                n_chain.d = r_chain.d + r_work.d;
                n_chain.e = r_chain.e + r_work.e;
            end
            ST_PAD: begin
                n_pad_first = 1'b0;
                n_len_phase = r_len_phase | (!r_pad_first && (r_pos == LEN_POS));
                if (wrap && r_len_phase) n_final_blk = 1'b1;
            end
            ST_OUT: begin
                if (out_acc) n_out_idx = r_out_idx + 3'd1;
                if (out_done) begin
                    n_out_idx   = 3'd0;
                    n_chain     = SHA1_IV;
                    n_bit_len   = 64'd0;
                    n_finish    = 1'b0;
                    n_len_phase = 1'b0;
                    n_final_blk = 1'b0;
                end
            end
            default: begin
                n_out_idx = r_out_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chain     <= SHA1_IV;
            r_work      <= '0;
            r_pos       <= 6'd0;
            r_bit_len   <= 64'd0;
            r_round     <= 7'd0;
            r_finish    <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_phase <= 1'b0;
            r_final_blk <= 1'b0;
            r_out_idx   <= 3'd0;
        end else begin
            r_state     <= n_state;
            r_chain     <= n_chain;
            r_work      <= n_work;
            r_pos       <= n_pos;
            r_bit_len   <= n_bit_len;
            r_round     <= n_round;
            r_finish    <= n_finish;
            r_pad_first <= n_pad_first;
            r_len_phase <= n_len_phase;
            r_final_blk <= n_final_blk;
            r_out_idx   <= n_out_idx;
        end
    end

    // block words: payload only, every slot is written before it is used
    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
    end

endmodule
`default_nettype wire

[rtl/sha1s_checker.sv]
`default_nettype none
module sha1s_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // no input taken while a digest is going out
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while digest pending");

    a_last_on_fifth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd4)))
        else $error("tlast not on word 4");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1)))
        else $error("digest word index skipped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled digest word changed");

endmodule

bind sha1_stream_hash sha1s_checker u_sha1s_checker (.*);
`default_nettype wire
